### rtl/core/tdt_pkg.sv
// Shared types, constants and helpers for the table-driven DFA tokenizer.
`timescale 1ns / 1ps

package tdt_pkg;

    localparam int STATE_W      = 6;
    localparam int CHAR_W       = 8;
    localparam int KIND_W       = 8;
    localparam int CLASS_W      = 2;
    localparam int OP_W         = 2;
    localparam int TOK_LEN_W    = 16;
    localparam int EDGE_W       = STATE_W + 1;
    localparam int ATTR_W       = KIND_W + 1;
    localparam int OUT_DEPTH    = 4;

    localparam int NUM_STATES_DEF = 64;
    localparam int LEN_BITS_DEF   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR = 2'd0,
        OP_EDGE = 2'd1,
        OP_ATTR = 2'd2,
        OP_END  = 2'd3
    } t_op;

    typedef enum logic [CLASS_W-1:0] {
        CLS_TOKEN   = 2'd0,
        CLS_INVALID = 2'd1,
        CLS_EOF     = 2'd2
    } t_class;

    typedef struct packed {
        t_class                 token_class;
        logic [KIND_W-1:0]      token_kind;
        logic [TOK_LEN_W-1:0]   token_length;
        logic                   last_result;
    } t_result;

    // Everything the step logic learns from the memories for one item.
    typedef struct packed {
        logic               a_hit;
        logic [STATE_W-1:0] a_dst;
        logic               b_hit;
        logic [STATE_W-1:0] b_dst;
        logic               fin;
        logic [KIND_W-1:0]  kind;
    } t_lookup;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_step_res;

    function automatic logic state_in_range(input logic [STATE_W-1:0] s,
                                            input int unsigned n);
        return 32'(s) < 32'(n);
    endfunction

endpackage

### rtl/core/tdt_item_if.sv
// Input item channel: valid/ready handshake with the load and character fields.
`timescale 1ns / 1ps

interface tdt_item_if import tdt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [CHAR_W-1:0]  char_code;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic               edge_present;
    logic               accepting;
    logic [KIND_W-1:0]  kind_code;

    modport source (
        output valid, operation, char_code, from_state, to_state, edge_present,
               accepting, kind_code,
        input  ready
    );
    modport sink (
        input  valid, operation, char_code, from_state, to_state, edge_present,
               accepting, kind_code,
        output ready
    );
endinterface

### rtl/core/tdt_result_if.sv
// Result item channel: valid/ready handshake with the token fields.
`timescale 1ns / 1ps

interface tdt_result_if import tdt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CLASS_W-1:0]   token_class;
    logic [KIND_W-1:0]    token_kind;
    logic [TOK_LEN_W-1:0] token_length;
    logic                 last_result;

    modport source (
        output valid, token_class, token_kind, token_length, last_result,
        input  ready
    );
    modport sink (
        input  valid, token_class, token_kind, token_length, last_result,
        output ready
    );
endinterface

### rtl/core/tdt_cfg_if.sv
// Configuration write channel carrying the start state register.
`timescale 1ns / 1ps

interface tdt_cfg_if import tdt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] start_state;

    modport source (output valid, start_state, input ready);
    modport sink   (input valid, start_state, output ready);
endinterface

### rtl/core/tdt_ram.sv
// Generic RAM with one write port and one or more registered read ports.
`timescale 1ns / 1ps

module tdt_ram #(
    parameter int DATA_W     = 8,
    parameter int DEPTH      = 64,
    parameter int READ_PORTS = 1,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr [READ_PORTS],
    output logic [DATA_W-1:0] o_rdata [READ_PORTS]
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    for (genvar p = 0; p < READ_PORTS; p++) begin : g_rd
        always_ff @(posedge i_clk) begin
            if (i_re) begin
                o_rdata[p] <= r_mem[i_raddr[p]];
            end
        end
    end

endmodule

### rtl/core/tdt_step.sv
// Per-item decision logic: next state, token length and emitted results.
`timescale 1ns / 1ps

module tdt_step import tdt_pkg::*; #(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  t_op                 i_op,
    input  t_lookup             i_look,
    input  logic [STATE_W-1:0]  i_cur,
    input  logic [LEN_BITS-1:0] i_len,
    output logic [STATE_W-1:0]  o_cur,
    output logic [LEN_BITS-1:0] o_len,
    output t_step_res           o_res
);

    t_result pend;
    t_result bad1;
    t_result eof;

    always_comb begin
        // Token that closes the pending characters.
        pend              = '0;
        pend.token_class  = i_look.fin ? CLS_TOKEN : CLS_INVALID;
        pend.token_kind   = i_look.fin ? i_look.kind : '0;
        pend.token_length = TOK_LEN_W'(i_len);
        pend.last_result  = 1'b0;

        bad1              = '0;
        bad1.token_class  = CLS_INVALID;
        bad1.token_length = TOK_LEN_W'(1);
        bad1.last_result  = 1'b1;

        eof               = '0;
        eof.token_class   = CLS_EOF;
        eof.last_result   = 1'b1;

        o_cur = i_cur;
        o_len = i_len;
        o_res = '0;

        case (i_op)
            OP_CHAR: begin
                if (i_look.a_hit) begin
                    o_cur = i_look.a_dst;
                    if (i_len != '1) begin
                        o_len = i_len + LEN_BITS'(1);
                    end
                end else if (i_len != '0) begin
                    o_res.r0    = pend;
                    o_res.count = 2'd1;
                    if (i_look.b_hit) begin
                        // The character opens a new token from the start row.
                        o_res.r0.last_result = 1'b1;
                        o_cur = i_look.b_dst;
                        o_len = LEN_BITS'(1);
                    end else begin
                        o_res.r1    = bad1;
                        o_res.count = 2'd2;
                        o_len       = '0;
                    end
                end else begin
                    o_res.r0    = bad1;
                    o_res.count = 2'd1;
                    o_len       = '0;
                end
            end
            OP_END: begin
                if (i_len != '0) begin
                    o_res.r0    = pend;
                    o_res.r1    = eof;
                    o_res.count = 2'd2;
                end else begin
                    o_res.r0    = eof;
                    o_res.count = 2'd1;
                end
                o_len = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/core/tdt_out_fifo.sv
// Result queue that takes up to two items per cycle and sends one per handshake.
`timescale 1ns / 1ps

module tdt_out_fifo import tdt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_push_count,
    input  t_result      i_push0,
    input  t_result      i_push1,
    output logic         o_room,
    tdt_result_if.source o_result
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_result            r_mem [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr_ptr1;
    logic               pop;
    t_result            head;

    assign n_wr_ptr1 = r_wr_ptr + PTR_W'(1);
    assign pop       = o_result.valid & o_result.ready;
    assign o_room    = r_cnt <= CNT_W'(OUT_DEPTH - 2);
    assign head      = r_mem[r_rd_ptr];

    assign o_result.valid        = r_cnt != '0;
    assign o_result.token_class  = head.token_class;
    assign o_result.token_kind   = head.token_kind;
    assign o_result.token_length = head.token_length;
    assign o_result.last_result  = head.last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_count);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_cnt    <= r_cnt + CNT_W'(i_push_count) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[n_wr_ptr1] <= i_push1;
        end
    end

endmodule

### rtl/core/table_dfa_tokenizer.sv
// Top level of the table-driven DFA tokenizer.
`timescale 1ns / 1ps

// The tokenizer runs a DFA whose transitions and per-state attributes are
// loaded through the item channel, then turns a stream of character items into
// tokens of kind, class and saturating length; an end item flushes the pending
// token and closes with an end-of-file result. It accepts one item per clock
// cycle while the result queue has room for two results: the rate is set by
// the loop from the transition memory's registered read data through the
// next-state select back to the memory's read address, and the start-state
// row is fetched on a second read port in the same cycle, so restarting a
// token after a failed transition costs nothing. Results pass from the
// decision stage into the result queue and from there onto the result
// channel; an item that produces two results puts both into the queue at
// once, and the small queue lets input keep flowing while results wait. After
// reset the block sweeps the transition memory clean, one entry per cycle,
// and accepts no input item until that pass is done; configuration writes
// are taken at any time but must only be issued while the block is idle.

module table_dfa_tokenizer import tdt_pkg::*; #(
    parameter int NUM_STATES = NUM_STATES_DEF,
    parameter int LEN_BITS   = LEN_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdt_cfg_if.sink      i_cfg,
    tdt_item_if.sink     i_item,
    tdt_result_if.source o_result
);

    localparam int ST_BITS = $clog2(NUM_STATES);
    localparam int E_DEPTH = NUM_STATES * (2 ** CHAR_W);
    localparam int E_AW    = ST_BITS + CHAR_W;

    // Architectural state.
    logic [STATE_W-1:0]  r_start;
    logic [STATE_W-1:0]  r_cur;
    logic [LEN_BITS-1:0] r_len;

    // Item held in the decision stage; the memory read data belongs to it.
    logic                r_stg_vld;
    t_op                 r_op;
    logic                r_look_ok;
    logic                r_start_ok;
    logic                r_attr_ok;

    // Clearing pass after reset.
    logic                r_clr_busy;
    logic [E_AW-1:0]     r_clr_addr;

    logic [STATE_W-1:0]  n_cur;
    logic [LEN_BITS-1:0] n_len;
    logic [STATE_W-1:0]  look_state;
    logic                accept;
    logic                stg_retire;
    logic                out_room;
    t_op                 in_op;
    logic                from_ok;
    logic                to_ok;

    logic                edge_we;
    logic [E_AW-1:0]     edge_waddr;
    logic [EDGE_W-1:0]   edge_wdata;
    logic [E_AW-1:0]     edge_raddr [2];
    logic [EDGE_W-1:0]   edge_rdata [2];

    logic                attr_we;
    logic [ST_BITS-1:0]  attr_waddr;
    logic [ATTR_W-1:0]   attr_wdata;
    logic [ST_BITS-1:0]  attr_raddr [1];
    logic [ATTR_W-1:0]   attr_rdata [1];

    t_lookup             look;
    logic [STATE_W-1:0]  step_cur;
    logic [LEN_BITS-1:0] step_len;
    t_step_res           step_res;
    logic [1:0]          push_count;

    assign i_cfg.ready = 1'b1;

    // The stage hands its item on when the queue can take two results.
    assign stg_retire   = r_stg_vld & out_room;
    assign i_item.ready = !r_clr_busy & (!r_stg_vld | stg_retire);
    assign accept       = i_item.valid & i_item.ready;
    assign push_count   = stg_retire ? step_res.count : 2'd0;

    // State as it stands once the staged item has finished, which is what the
    // incoming item must look up from.
    assign n_cur      = stg_retire ? step_cur : r_cur;
    assign n_len      = stg_retire ? step_len : r_len;
    assign look_state = (n_len == '0) ? r_start : n_cur;

    assign in_op   = t_op'(i_item.operation);
    assign from_ok = state_in_range(i_item.from_state, NUM_STATES);
    assign to_ok   = state_in_range(i_item.to_state, NUM_STATES);

    // Loads write at the edge that accepts them; the sweep owns the port first.
    always_comb begin
        edge_we    = 1'b0;
        edge_waddr = {ST_BITS'(i_item.from_state), i_item.char_code};
        edge_wdata = '0;
        attr_we    = 1'b0;
        attr_waddr = ST_BITS'(i_item.from_state);
        attr_wdata = {i_item.accepting, i_item.kind_code};
        if (r_clr_busy) begin
            edge_we    = 1'b1;
            edge_waddr = r_clr_addr;
            attr_we    = 1'b1;
            attr_waddr = r_clr_addr[E_AW-1:CHAR_W];
            attr_wdata = '0;
        end else if (accept) begin
            if (in_op == OP_EDGE && from_ok) begin
                if (!i_item.edge_present) begin
                    edge_we = 1'b1;
                end else if (to_ok) begin
                    edge_we    = 1'b1;
                    edge_wdata = {1'b1, i_item.to_state};
                end
            end
            if (in_op == OP_ATTR && from_ok) begin
                attr_we = 1'b1;
            end
        end
    end

    assign edge_raddr[0] = {ST_BITS'(look_state), i_item.char_code};
    assign edge_raddr[1] = {ST_BITS'(r_start), i_item.char_code};
    assign attr_raddr[0] = ST_BITS'(n_cur);

    tdt_ram #(
        .DATA_W     (EDGE_W),
        .DEPTH      (E_DEPTH),
        .READ_PORTS (2)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_re    (accept),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    tdt_ram #(
        .DATA_W     (ATTR_W),
        .DEPTH      (NUM_STATES),
        .READ_PORTS (1)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (attr_we),
        .i_waddr (attr_waddr),
        .i_wdata (attr_wdata),
        .i_re    (accept),
        .i_raddr (attr_raddr),
        .o_rdata (attr_rdata)
    );

    // States beyond the table have no transitions and are never final.
    always_comb begin
        look.a_hit = r_look_ok & edge_rdata[0][EDGE_W-1];
        look.a_dst = edge_rdata[0][STATE_W-1:0];
        look.b_hit = r_start_ok & edge_rdata[1][EDGE_W-1];
        look.b_dst = edge_rdata[1][STATE_W-1:0];
        look.fin   = r_attr_ok & attr_rdata[0][ATTR_W-1];
        look.kind  = attr_rdata[0][KIND_W-1:0];
    end

    tdt_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .i_op   (r_op),
        .i_look (look),
        .i_cur  (r_cur),
        .i_len  (r_len),
        .o_cur  (step_cur),
        .o_len  (step_len),
        .o_res  (step_res)
    );

    tdt_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_push0      (step_res.r0),
        .i_push1      (step_res.r1),
        .o_room       (out_room),
        .o_result     (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_cur      <= '0;
            r_len      <= '0;
            r_stg_vld  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_start <= i_cfg.start_state;
            end
            r_cur     <= n_cur;
            r_len     <= n_len;
            r_stg_vld <= accept | (r_stg_vld & !stg_retire);
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + E_AW'(1);
                if (r_clr_addr == E_AW'(E_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= in_op;
            r_look_ok  <= state_in_range(look_state, NUM_STATES);
            r_start_ok <= state_in_range(r_start, NUM_STATES);
            r_attr_ok  <= state_in_range(n_cur, NUM_STATES);
        end
    end

`ifndef SYNTHESIS
    // No item may enter while the transition memory is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !accept)
        else $error("item accepted during the clearing pass");

    // An end item always leaves no pending token behind.
    a_end_clears_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stg_retire && r_op == OP_END) |=> (r_len == '0))
        else $error("pending length not cleared by an end item");

    // Results pushed by a retiring item show up on the result channel.
    a_results_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stg_retire && step_res.count != 2'd0) |=> o_result.valid)
        else $error("retired results not presented");

    // Load and configuration items never produce results.
    a_loads_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stg_vld && (r_op == OP_EDGE || r_op == OP_ATTR)) |-> (step_res.count == 2'd0))
        else $error("load item produced a result");
`endif

endmodule

### tb/sv/table_dfa_tokenizer_test.sv
// Self-checking testbench for the table-driven DFA tokenizer.
`timescale 1ns / 1ps

module table_dfa_tokenizer_test;
    import tdt_pkg::*;

    // The block can accept nothing for a whole clearing sweep of the
    // transition memory after reset, so the idle limit sits well above it.
    localparam int CLEAR_CYCLES   = NUM_STATES_DEF * 256;
    localparam int WATCHDOG_LIMIT = 4 * CLEAR_CYCLES;
    localparam int IDLE_SETTLE    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 550;
    localparam int LONG_TOKEN     = 40;
    localparam int MAX_REPORTS    = 10;
    localparam logic [TOK_LEN_W-1:0] LEN_MAX = {TOK_LEN_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B = 8'h62;
    localparam logic [CHAR_W-1:0] CH_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_Z = 8'h7A;

    // One input item with every field of the item channel.
    typedef struct packed {
        t_op                op;
        logic [CHAR_W-1:0]  char_code;
        logic [STATE_W-1:0] from_state;
        logic [STATE_W-1:0] to_state;
        logic               edge_present;
        logic               accepting;
        logic [KIND_W-1:0]  kind_code;
    } t_lex_item;

    logic i_clk;
    logic i_rst_n;

    tdt_cfg_if    cfg_ch ();
    tdt_item_if   item_ch ();
    tdt_result_if res_ch ();

    table_dfa_tokenizer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    // Predicted lexer state: transition entries (present bit and target),
    // per-state attributes, the start register and the pending token.
    logic [STATE_W:0]     m_edge [0:NUM_STATES_DEF-1][0:255];
    logic                 m_accepting [0:NUM_STATES_DEF-1];
    logic [KIND_W-1:0]    m_kind [0:NUM_STATES_DEF-1];
    logic [STATE_W-1:0]   m_start;
    logic [STATE_W-1:0]   m_state;
    logic [TOK_LEN_W-1:0] m_len;

    t_result tokens_due[$];

    int  send_gap_max = 15;
    int  rcv_gap_max  = 15;
    int  rcv_wait     = 0;
    bit  rcv_hold     = 1'b0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  cfg_writes   = 0;
    int  mismatches   = 0;
    int  quiet_cycles = 0;
    int  lexer_phases = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic t_result make_token(t_class cls, logic [KIND_W-1:0] kind,
                                           logic [TOK_LEN_W-1:0] len);
        t_result r;
        r.token_class  = cls;
        r.token_kind   = kind;
        r.token_length = len;
        r.last_result  = 1'b0;
        return r;
    endfunction

    // Closes the pending token: recognized if its state is final, invalid
    // otherwise. The automaton goes back to the start state either way.
    function automatic t_result close_pending();
        t_result r;
        if (m_accepting[m_state]) begin
            r = make_token(CLS_TOKEN, m_kind[m_state], m_len);
        end else begin
            r = make_token(CLS_INVALID, '0, m_len);
        end
        m_state = m_start;
        m_len   = '0;
        return r;
    endfunction

    // Applies one accepted item to the predicted state and queues the
    // tokens it produces, flagging the last one.
    function automatic void predict_tokens(t_lex_item it);
        t_result       res[$];
        logic [STATE_W:0] hop;
        case (it.op)
            OP_EDGE: begin
                m_edge[it.from_state][it.char_code] =
                    it.edge_present ? {1'b1, it.to_state} : '0;
            end
            OP_ATTR: begin
                m_accepting[it.from_state] = it.accepting;
                m_kind[it.from_state]      = it.kind_code;
            end
            OP_END: begin
                if (m_len != 0) begin
                    res.push_back(close_pending());
                end
                res.push_back(make_token(CLS_EOF, '0, '0));
                m_state = m_start;
                m_len   = '0;
            end
            default: begin
                // With no token pending, the lookup starts from the start
                // register, so a register change lands at the next token.
                if (m_len == 0) begin
                    m_state = m_start;
                end
                hop = m_edge[m_state][it.char_code];
                if (hop[STATE_W]) begin
                    m_state = hop[STATE_W-1:0];
                    if (m_len != LEN_MAX) begin
                        m_len = m_len + 1'b1;
                    end
                end else begin
                    // No transition: close the pending token and try the
                    // same character again from the start state.
                    if (m_len != 0) begin
                        res.push_back(close_pending());
                        hop = m_edge[m_state][it.char_code];
                    end
                    if (hop[STATE_W] && res.size() != 0) begin
                        m_state = hop[STATE_W-1:0];
                        m_len   = TOK_LEN_W'(1);
                    end else begin
                        // A character that is dead from the start state
                        // becomes a one-character invalid token.
                        res.push_back(make_token(CLS_INVALID, '0, TOK_LEN_W'(1)));
                        m_state = m_start;
                        m_len   = '0;
                    end
                end
            end
        endcase
        if (res.size() != 0) begin
            res[$].last_result = 1'b1;
        end
        foreach (res[i]) begin
            tokens_due.push_back(res[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: every handshake is observed here, in one process, so the
    // result check always runs before the prediction of an item accepted
    // at the same edge. It also runs the idle watchdog.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : monitor
        t_result   got;
        t_result   want;
        t_lex_item seen;
        bit        active;
        if (i_rst_n) begin
            active = 1'b0;
            if (res_ch.valid && res_ch.ready) begin
                active             = 1'b1;
                got.token_class    = t_class'(res_ch.token_class);
                got.token_kind     = res_ch.token_kind;
                got.token_length   = res_ch.token_length;
                got.last_result    = res_ch.last_result;
                results_seen++;
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Unexpected result: class %0d kind %02h length %0d last %0b",
                                 got.token_class, got.token_kind, got.token_length,
                                 got.last_result);
                    end
                end else begin
                    want = tokens_due.pop_front();
                    if (got.token_class !== want.token_class ||
                        got.token_kind !== want.token_kind ||
                        got.token_length !== want.token_length ||
                        got.last_result !== want.last_result) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("Mismatch at result %0d: expected class %0d kind %02h %s",
                                     results_seen, want.token_class, want.token_kind,
                                     $sformatf("length %0d last %0b", want.token_length,
                                               want.last_result));
                            $display("    got class %0d kind %02h length %0d last %0b",
                                     got.token_class, got.token_kind, got.token_length,
                                     got.last_result);
                        end
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                active  = 1'b1;
                m_start = cfg_ch.start_state;
                cfg_writes++;
            end
            if (item_ch.valid && item_ch.ready) begin
                active            = 1'b1;
                seen.op           = t_op'(item_ch.operation);
                seen.char_code    = item_ch.char_code;
                seen.from_state   = item_ch.from_state;
                seen.to_state     = item_ch.to_state;
                seen.edge_present = item_ch.edge_present;
                seen.accepting    = item_ch.accepting;
                seen.kind_code    = item_ch.kind_code;
                predict_tokens(seen);
            end
            if (active) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results still due",
                         quiet_cycles, tokens_due.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result receiver. After each accepted result it drops ready for a
    // random number of cycles; a hold request keeps ready low regardless.
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) begin
            rcv_wait = (rcv_gap_max == 0) ? 0 : $urandom_range(0, rcv_gap_max);
        end else if (rcv_wait > 0) begin
            rcv_wait = rcv_wait - 1;
        end
        res_ch.ready <= i_rst_n && !rcv_hold && rcv_wait == 0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Every field random, so fields that an operation ignores still toggle.
    function automatic t_lex_item rand_item();
        t_lex_item it;
        it.op           = t_op'($urandom_range(0, 3));
        it.char_code    = CHAR_W'($urandom_range(0, 255));
        it.from_state   = STATE_W'($urandom_range(0, NUM_STATES_DEF - 1));
        it.to_state     = STATE_W'($urandom_range(0, NUM_STATES_DEF - 1));
        it.edge_present = 1'($urandom_range(0, 1));
        it.accepting    = 1'($urandom_range(0, 1));
        it.kind_code    = KIND_W'($urandom_range(0, 255));
        return it;
    endfunction

    // Offers one item after a random gap and returns at the edge where it
    // is taken; valid stays high so back-to-back items need no bubble.
    task automatic send_item(t_lex_item it);
        int gap;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= it.op;
        item_ch.char_code    <= it.char_code;
        item_ch.from_state   <= it.from_state;
        item_ch.to_state     <= it.to_state;
        item_ch.edge_present <= it.edge_present;
        item_ch.accepting    <= it.accepting;
        item_ch.kind_code    <= it.kind_code;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_char(logic [CHAR_W-1:0] ch);
        t_lex_item it;
        it           = rand_item();
        it.op        = OP_CHAR;
        it.char_code = ch;
        send_item(it);
    endtask

    task automatic send_end();
        t_lex_item it;
        it    = rand_item();
        it.op = OP_END;
        send_item(it);
    endtask

    task automatic load_edge(logic [STATE_W-1:0] from, logic [CHAR_W-1:0] ch,
                             logic [STATE_W-1:0] to, logic present);
        t_lex_item it;
        it              = rand_item();
        it.op           = OP_EDGE;
        it.from_state   = from;
        it.char_code    = ch;
        it.to_state     = to;
        it.edge_present = present;
        send_item(it);
    endtask

    task automatic load_attr(logic [STATE_W-1:0] from, logic acc, logic [KIND_W-1:0] kind);
        t_lex_item it;
        it            = rand_item();
        it.op         = OP_ATTR;
        it.from_state = from;
        it.accepting  = acc;
        it.kind_code  = kind;
        send_item(it);
    endtask

    // Stops offering items and waits until every predicted result has come
    // back. Load items leave nothing to wait for, so a further settling wait
    // lets the last of them land in the memories.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Writes the start register; only called while the block is idle.
    task automatic write_start(logic [STATE_W-1:0] value);
        cfg_ch.start_state <= value;
        cfg_ch.valid       <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With an empty table, every character is dead from the start state,
    // and an end item with nothing pending gives only end of file.
    task automatic test_dead_start_after_reset();
        send_char(8'h00);
        send_char(8'hFF);
        send_end();
        wait_idle();
    endtask

    // Tokens that close on a failed transition, a non-final state turning
    // into an invalid token, one item causing two results, an end item
    // with a token pending, and removal of a transition.
    task automatic test_token_rules();
        load_attr(6'd1, 1'b1, 8'h11);
        load_attr(6'd2, 1'b0, 8'h5A);
        load_edge(6'd0, CH_A, 6'd1, 1'b1);
        load_edge(6'd1, CH_A, 6'd1, 1'b1);
        load_edge(6'd0, CH_B, 6'd2, 1'b1);
        send_char(CH_A);
        send_char(CH_A);
        send_char(CH_B);
        send_char(CH_X);
        send_char(CH_A);
        send_end();
        load_edge(6'd1, CH_A, 6'd0, 1'b0);
        send_char(CH_A);
        send_char(CH_A);
        send_end();
        wait_idle();
    endtask

    // A change of the start register while a token is pending only takes
    // effect once that token closes. Both register extremes are used.
    task automatic test_start_register();
        write_start(6'd63);
        load_attr(6'd63, 1'b1, 8'hFF);
        load_attr(6'd0, 1'b1, 8'h00);
        load_edge(6'd63, 8'h00, 6'd0, 1'b1);
        send_char(8'h00);
        wait_idle();
        write_start(6'd0);
        send_char(8'h00);
        send_char(CH_A);
        send_end();
        wait_idle();
        write_start(6'd63);
        send_char(8'h00);
        send_end();
        wait_idle();
    endtask

    // A self loop on the start state builds one long token that one more
    // character extends and an end item closes; sent back to back with no gaps.
    task automatic test_long_token();
        send_gap_max = 0;
        load_edge(6'd63, 8'hFF, 6'd63, 1'b1);
        for (int i = 0; i < LONG_TOKEN; i++) begin
            send_char(8'hFF);
        end
        send_char(8'h00);
        send_end();
        wait_idle();
        send_gap_max = 15;
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items, every other one causing two results, so the result queue fills
    // and the input side has to stall.
    task automatic test_output_backpressure();
        write_start(6'd0);
        load_edge(6'd1, CH_A, 6'd1, 1'b1);
        wait_idle();
        send_gap_max = 0;
        fork
            begin
                rcv_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rcv_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 20; i++) begin
            send_char(CH_A);
            send_char(CH_Z);
        end
        send_end();
        wait_idle();
        send_gap_max = 15;
    endtask

    // Random small lexers: two to six states over a four-letter alphabet,
    // then streams drawn mostly from that alphabet, with noise characters,
    // stray load items, early end items and full drains mixed in.
    task automatic test_random_lexers();
        logic [STATE_W-1:0] st[6];
        logic [CHAR_W-1:0]  alpha[4];
        int                 n_states;
        int                 stream_len;
        int                 pick;
        int                 base;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            wait_idle();
            lexer_phases++;
            // Each side runs with no idling in about a quarter of the phases.
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            rcv_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 15;
            n_states = $urandom_range(2, 6);
            foreach (st[i]) begin
                st[i] = STATE_W'($urandom_range(0, NUM_STATES_DEF - 1));
            end
            foreach (alpha[i]) begin
                alpha[i] = CHAR_W'($urandom_range(0, 255));
            end
            write_start(st[0]);
            for (int s = 0; s < n_states; s++) begin
                load_attr(st[3'(s)], $urandom_range(0, 3) != 0,
                          KIND_W'($urandom_range(0, 255)));
                for (int c = 0; c < 4; c++) begin
                    load_edge(st[3'(s)], alpha[2'(c)],
                              st[3'($urandom_range(0, n_states - 1))],
                              $urandom_range(0, 9) < 7);
                end
            end
            stream_len = $urandom_range(10, 60);
            for (int k = 0; k < stream_len; k++) begin
                pick = $urandom_range(0, 39);
                if (pick < 2) begin
                    send_item(rand_item());
                end else if (pick < 4) begin
                    send_char(CHAR_W'($urandom_range(0, 255)));
                end else if (pick == 4) begin
                    send_end();
                end else if (pick == 5) begin
                    wait_idle();
                end else begin
                    send_char(alpha[2'($urandom_range(0, 3))]);
                end
            end
            send_end();
        end
        send_gap_max = 15;
        rcv_gap_max  = 15;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        // Predicted state starts as after reset: no transitions, no final
        // states, start register zero.
        foreach (m_edge[s, c]) begin
            m_edge[s][c] = '0;
        end
        foreach (m_accepting[s]) begin
            m_accepting[s] = 1'b0;
            m_kind[s]      = '0;
        end
        m_start = '0;
        m_state = '0;
        m_len   = '0;

        i_rst_n              = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.start_state   = '0;
        item_ch.valid        = 1'b0;
        item_ch.operation    = OP_CHAR;
        item_ch.char_code    = '0;
        item_ch.from_state   = '0;
        item_ch.to_state     = '0;
        item_ch.edge_present = 1'b0;
        item_ch.accepting    = 1'b0;
        item_ch.kind_code    = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_dead_start_after_reset();
        test_token_rules();
        test_start_register();
        test_long_token();
        test_output_backpressure();
        test_random_lexers();

        wait_idle();
        repeat (4 * IDLE_SETTLE) @(posedge i_clk);

        if (tokens_due.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", tokens_due.size());
        end

        $display("Sent %0d items and checked %0d results over %0d start-state writes",
                 items_sent, results_seen, cfg_writes);
        $display("Covered dead starts, token closes, a long token and a long result stall");
        $display("plus %0d random lexers; %0d mismatches", lexer_phases, mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
